FILE: rtl/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg: bracket balance checker package
// Transaction types, result kinds, bracket characters and code helpers.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } bbc_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] err_position;
    logic [7:0]  char_out;
    logic        run_end;
  } bbc_out_t;

  localparam logic [1:0] KIND_BALANCED = 2'd0;
  localparam logic [1:0] KIND_MISMATCH = 2'd1;
  localparam logic [1:0] KIND_CLOSER   = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // Bracket codes held on the stack; CODE_NONE marks any other byte
  localparam logic [1:0] CODE_NONE  = 2'd0;
  localparam logic [1:0] CODE_ROUND = 2'd1;
  localparam logic [1:0] CODE_SQUARE = 2'd2;
  localparam logic [1:0] CODE_CURLY = 2'd3;

  localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;  // }

  function automatic logic [1:0] open_code_of(input logic [7:0] ch);
    logic [1:0] code;
    code = CODE_NONE;
    if (ch == CHAR_OPEN_ROUND)       code = CODE_ROUND;
    else if (ch == CHAR_OPEN_SQUARE) code = CODE_SQUARE;
    else if (ch == CHAR_OPEN_CURLY)  code = CODE_CURLY;
    return code;
  endfunction

  function automatic logic [1:0] close_code_of(input logic [7:0] ch);
    logic [1:0] code;
    code = CODE_NONE;
    if (ch == CHAR_CLOSE_ROUND)       code = CODE_ROUND;
    else if (ch == CHAR_CLOSE_SQUARE) code = CODE_SQUARE;
    else if (ch == CHAR_CLOSE_CURLY)  code = CODE_CURLY;
    return code;
  endfunction

  function automatic logic [7:0] closer_of(input logic [1:0] code);
    logic [7:0] ch;
    unique case (code)
      CODE_ROUND:  ch = CHAR_CLOSE_ROUND;
      CODE_SQUARE: ch = CHAR_CLOSE_SQUARE;
      CODE_CURLY:  ch = CHAR_CLOSE_CURLY;
      default:     ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bracket_balance_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming balanced-bracket checker
// Checks nesting of ( [ { ) ] } over a byte stream, one string per run.
// ----------------------------------------------------------------------------
// One character is taken per input transaction; is_final marks the last one.
// Opening brackets are pushed as 2-bit codes into a STACK_DEPTH-entry stack
// RAM; a closing bracket pops its partner. The first bad closer (empty stack
// or wrong partner) gives a mismatch result, a push onto a full stack gives
// an overflow result; both carry the character and its position (saturating
// at 65535), and the rest of the string is then dropped up to is_final. At
// the end of a clean string the block gives either one balanced result or the
// closing character of every open bracket, innermost first, with run_end on
// the last. A character takes two steps (accept with RAM read of the stack
// top, then compare and write back), as RAM read data is registered; no
// new character is taken until both are done. Draining has a read and a
// wait step per open bracket. A result waits in the output register while
// the next character is accepted; the block only stalls when a new result
// meets a full output register. The stack RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire bbc_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output bbc_out_t     out_data
);

  // Address width of the stack RAM, and a pointer wide enough to hold the
  // depth itself (stack full)
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE       = 2'd0;
  localparam logic [1:0] S_EXEC       = 2'd1;
  localparam logic [1:0] S_DRAIN_RD   = 2'd2;
  localparam logic [1:0] S_DRAIN_WAIT = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [TW-1:0] top_r, top_nxt;        // open brackets held
  logic [15:0]   idx_r, idx_nxt;        // position of next character
  logic          failed_r, failed_nxt;
  logic [7:0]    ch_r;                  // character under work
  logic          fin_r;

  logic          out_valid_r, out_valid_nxt;
  bbc_out_t      out_data_r, out_data_nxt;
  logic          out_free;

  // Stack RAM ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [1:0]    rd_data;

  // Decoded character in the execute step
  logic [1:0]    open_code;
  logic [1:0]    close_code;
  logic [15:0]   idx_inc;
  logic [TW-1:0] top_dec;

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign open_code  = open_code_of(ch_r);
  assign close_code = close_code_of(ch_r);
  assign idx_inc    = (idx_r != 16'hFFFF) ? idx_r + 16'd1 : idx_r;
  assign top_dec    = top_r - TW'(1);

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    idx_nxt       = idx_r;
    failed_nxt    = failed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = top_r[AW-1:0];
    wr_data       = open_code;
    rd_en         = 1'b0;
    rd_addr       = top_dec[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        // Fetch the current stack top alongside the new character
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (failed_r) begin
          // Dropping the tail of a failed string
          if (fin_r) begin
            top_nxt    = '0;
            idx_nxt    = '0;
            failed_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end else if (open_code != CODE_NONE && top_r == TW'(STACK_DEPTH)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{KIND_OVERFLOW, idx_r, ch_r, fin_r};
            if (fin_r) begin
              top_nxt = '0;
              idx_nxt = '0;
            end else begin
              idx_nxt    = idx_inc;
              failed_nxt = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end else if (close_code != CODE_NONE &&
                     (top_r == '0 || rd_data != close_code)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{KIND_MISMATCH, idx_r, ch_r, fin_r};
            if (fin_r) begin
              top_nxt = '0;
              idx_nxt = '0;
            end else begin
              idx_nxt    = idx_inc;
              failed_nxt = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end else if (!fin_r) begin
          // Plain push, pop or other byte
          idx_nxt = idx_inc;
          if (open_code != CODE_NONE) begin
            wr_en   = 1'b1;
            top_nxt = top_r + TW'(1);
          end else if (close_code != CODE_NONE) begin
            top_nxt = top_dec;
          end
          state_nxt = S_IDLE;
        end else begin
          // Last character: work out the depth left after it
          if (open_code != CODE_NONE) begin
            wr_en     = 1'b1;
            top_nxt   = top_r + TW'(1);
            idx_nxt   = '0;
            state_nxt = S_DRAIN_RD;
          end else if (close_code != CODE_NONE && top_dec != '0) begin
            top_nxt   = top_dec;
            idx_nxt   = '0;
            state_nxt = S_DRAIN_RD;
          end else if (close_code == CODE_NONE && top_r != '0) begin
            idx_nxt   = '0;
            state_nxt = S_DRAIN_RD;
          end else if (out_free) begin
            // Stack ends empty
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{KIND_BALANCED, 16'd0, 8'd0, 1'b1};
            top_nxt       = '0;
            idx_nxt       = '0;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_DRAIN_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_DRAIN_WAIT;
      end

      S_DRAIN_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{KIND_CLOSER, 16'd0, closer_of(rd_data), top_r == TW'(1)};
          top_nxt       = top_dec;
          state_nxt     = (top_r == TW'(1)) ? S_IDLE : S_DRAIN_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      idx_r       <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      idx_r       <= idx_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r  <= in_data.char_in;
      fin_r <= in_data.is_final;
    end
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/bbc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: tb/bracket_balance_checker_tb.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_tb: self-checking bench for the bracket checker
// Character strings are streamed through the block. A scoreboard keeps a
// bracket stack of its own and queues the verdicts each character should
// produce; every result transaction is checked field by field against them.
// ----------------------------------------------------------------------------
import bbc_pkg::*;

// Returns {closing, code}; code is CODE_NONE for any non-bracket byte
function automatic logic [2:0] bracket_class(input logic [7:0] ch);
  case (ch)
    CHAR_OPEN_ROUND:   return {1'b0, CODE_ROUND};
    CHAR_OPEN_SQUARE:  return {1'b0, CODE_SQUARE};
    CHAR_OPEN_CURLY:   return {1'b0, CODE_CURLY};
    CHAR_CLOSE_ROUND:  return {1'b1, CODE_ROUND};
    CHAR_CLOSE_SQUARE: return {1'b1, CODE_SQUARE};
    CHAR_CLOSE_CURLY:  return {1'b1, CODE_CURLY};
    default:           return {1'b0, CODE_NONE};
  endcase
endfunction

function automatic logic [7:0] opening_char(input logic [1:0] code);
  case (code)
    CODE_ROUND:  return CHAR_OPEN_ROUND;
    CODE_SQUARE: return CHAR_OPEN_SQUARE;
    CODE_CURLY:  return CHAR_OPEN_CURLY;
    default:     return 8'h00;
  endcase
endfunction

function automatic logic [7:0] closing_char(input logic [1:0] code);
  case (code)
    CODE_ROUND:  return CHAR_CLOSE_ROUND;
    CODE_SQUARE: return CHAR_CLOSE_SQUARE;
    CODE_CURLY:  return CHAR_CLOSE_CURLY;
    default:     return 8'h00;
  endcase
endfunction

class bracket_tracker #(int DEPTH = 32);
  logic [1:0]  open_stack[DEPTH];
  int          depth;
  logic [15:0] index;
  bit          failed;
  bbc_out_t    expected_verdicts[$];
  int unsigned fails;

  function void restart();
    depth  = 0;
    index  = '0;
    failed = 1'b0;
  endfunction

  function void note(input logic [1:0] kind, input logic [15:0] pos,
                     input logic [7:0] ch, input logic last);
    bbc_out_t v;
    v.result_kind  = kind;
    v.err_position = pos;
    v.char_out     = ch;
    v.run_end      = last;
    expected_verdicts.push_back(v);
  endfunction

  // error verdict; a failure on the last character clears at once
  function void fail_here(input logic [1:0] kind, input logic [15:0] pos,
                          input bbc_in_t t);
    note(kind, pos, t.char_in, t.is_final);
    if (t.is_final) restart();
    else failed = 1'b1;
  endfunction

  function void take_char(input bbc_in_t t);
    logic [15:0] pos;
    logic [2:0]  cls;
    int          k;
    if (failed) begin
      if (t.is_final) restart();
      return;
    end
    pos = index;
    if (index != 16'hFFFF) index++;
    cls = bracket_class(t.char_in);
    if (cls[1:0] != CODE_NONE && !cls[2]) begin
      if (depth >= DEPTH) begin
        fail_here(KIND_OVERFLOW, pos, t);
        return;
      end
      open_stack[depth] = cls[1:0];
      depth++;
    end else if (cls[1:0] != CODE_NONE) begin
      if (depth == 0 || open_stack[depth-1] != cls[1:0]) begin
        fail_here(KIND_MISMATCH, pos, t);
        return;
      end
      depth--;
    end
    if (!t.is_final) return;
    if (depth == 0) begin
      note(KIND_BALANCED, '0, '0, 1'b1);
    end else begin
      for (k = depth - 1; k >= 0; k--)
        note(KIND_CLOSER, '0, closing_char(open_stack[k]), k == 0);
    end
    restart();
  endfunction

  function void check_verdict(input bbc_out_t got);
    bbc_out_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected result: kind %0d pos %0d char %0h run_end %0b",
             got.result_kind, got.err_position, got.char_out, got.run_end);
      fails++;
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
      fails++;
    end
    if (got.err_position !== want.err_position) begin
      $error("err_position: expected %0d, got %0d", want.err_position, got.err_position);
      fails++;
    end
    if (got.char_out !== want.char_out) begin
      $error("char_out: expected %0h, got %0h", want.char_out, got.char_out);
      fails++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
      fails++;
    end
  endfunction

  function int unsigned pending();
    return expected_verdicts.size();
  endfunction
endclass

module bracket_balance_checker_tb;

  localparam int STACK_DEPTH  = 32;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 430;
  // slowest legal run: about 500 transactions, even if each one drained a
  // full stack with stalls on every closer, stays under this timeout
  localparam int TIMEOUT_CYCLES = 1_000_000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bbc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bbc_out_t out_data;

  bracket_tracker #(STACK_DEPTH) tracker;

  // idling switches, flipped per string by the stimulus
  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;

  int unsigned items_sent = 0;
  logic [7:0]  text[$];

  bracket_balance_checker #(
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // One input transaction. An idle gap may come first, by random choice;
  // valid is otherwise held high from one character to the next, so it only
  // ever gets one update per edge.
  task automatic send_char(input logic [7:0] ch, input logic fin);
    int unsigned hold;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      hold = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: ch, is_final: fin};
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: let the scoreboard predict its verdicts
    tracker.take_char(in_data);
    items_sent++;
  endtask

  // Sends the current text buffer as one string, final flag on its last byte
  task automatic send_text();
    int i;
    for (i = 0; i < text.size(); i++)
      send_char(text[i], i == text.size() - 1);
  endtask

  task automatic load_text(input string s);
    int i;
    text.delete();
    for (i = 0; i < s.len(); i++)
      text.push_back(s[i]);
  endtask

  // Sender holds off until every predicted verdict has come out. It waits
  // on the clock before checking, so valid is never lowered and raised in one step.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted result transaction, then choose ready
  // for the next edge, with random stall bursts.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        tracker.check_verdict(out_data);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n_str, len, pick, variant, k, base;
    logic [1:0]  code;
    logic [1:0]  open_codes[$];
    bit          noisy, deep, quiet;

    tracker = new;
    tracker.restart();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // Directed strings
    load_text("([]{})");   // balanced, every bracket type
    send_text();
    load_text("({[");      // unclosed: drain of three closers, innermost first
    send_text();
    load_text(")");        // closer on an empty stack, also the last character
    send_text();
    load_text("(]x)");     // wrong partner; rest dropped, the final one clears
    send_text();
    text.delete();         // extreme bytes, no brackets: balanced
    text.push_back(8'h00);
    text.push_back(8'hFF);
    send_text();
    load_text("[(}");      // wrong partner on the last character
    send_text();
    wait_results();

    // Random strings. Mostly nested sequences with random filler; a quarter
    // carry noise; some fill the stack to the brim. The last fifth of the
    // run has no idling on either side.
    base  = items_sent;
    n_str = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      quiet     = (items_sent - base) >= (RANDOM_ITEMS * 4) / 5;
      gaps_on   = !quiet && $urandom_range(0, 3) != 0;
      stalls_on = !quiet && $urandom_range(0, 3) != 0;
      text.delete();
      open_codes.delete();

      // the first few include each full-stack variant once
      deep    = (n_str >= 2 && n_str <= 8 && n_str % 2 == 0) ||
                $urandom_range(0, 19) == 0;
      variant = (n_str >= 2 && n_str <= 8) ? n_str / 2 - 1 : $urandom_range(0, 3);

      if (deep) begin
        repeat (STACK_DEPTH) begin
          code = 2'($urandom_range(CODE_ROUND, CODE_CURLY));
          text.push_back(opening_char(code));
          open_codes.push_back(code);
        end
        case (variant)
          0: begin   // overflow, then a tail that is dropped
            text.push_back(opening_char(2'($urandom_range(CODE_ROUND, CODE_CURLY))));
            repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
          end
          1: text.push_back(opening_char(2'($urandom_range(CODE_ROUND, CODE_CURLY))));
          2: ;       // full stack at the end: longest drain
          default: begin
            while (open_codes.size() != 0) text.push_back(closing_char(open_codes.pop_back()));
          end
        endcase
      end else begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
        noisy = $urandom_range(0, 3) == 0;
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(0, 9);
          if (noisy && $urandom_range(0, 5) == 0) begin
            code = 2'($urandom_range(CODE_ROUND, CODE_CURLY));
            if ($urandom_range(0, 1) != 0) text.push_back(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1) != 0) text.push_back(closing_char(code));
            else text.push_back(opening_char(code));
          end else if (pick < 4 && open_codes.size() < STACK_DEPTH) begin
            code = 2'($urandom_range(CODE_ROUND, CODE_CURLY));
            text.push_back(opening_char(code));
            open_codes.push_back(code);
          end else if (pick < 7 && open_codes.size() != 0) begin
            text.push_back(closing_char(open_codes.pop_back()));
          end else begin
            text.push_back(8'($urandom_range(0, 255)));
          end
        end
        if ($urandom_range(0, 1) != 0) begin
          while (open_codes.size() != 0) text.push_back(closing_char(open_codes.pop_back()));
        end
      end

      send_text();
      if (n_str % 8 == 7) wait_results();
      n_str++;
    end

    // Drain: everything predicted must come out, then nothing more may
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4 * STACK_DEPTH + 16) @(posedge clk);

    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("[bracket_balance_checker] OK");
    end else begin
      $display("[bracket_balance_checker] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[bracket_balance_checker] ERROR");
    $finish;
  end

endmodule
